### rtl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern string matcher.
// Used by the controller, the datapath and the top level; no dependencies.
package mpsm_pkg;

   // Sizes of the trie and of the item fields.
   localparam int NODES        = 4096;
   localparam int NODE_W       = $clog2(NODES);
   localparam int CNT_W        = $clog2(NODES + 1);
   localparam int ALPHABET     = 26;
   localparam int SYM_W        = 5;
   localparam int MAX_LEN      = 16;
   localparam int DEPTH_W      = $clog2(MAX_LEN + 1);
   localparam int MAX_PATTERNS = 1023;
   localparam int ID_W         = 10;
   localparam int TAG_W        = 20;

   // Command codes of an input beat.
   typedef enum logic [2:0] {
      CMD_INSERT  = 3'd0,
      CMD_END     = 3'd1,
      CMD_BUILD   = 3'd2,
      CMD_RESTART = 3'd3,
      CMD_SCAN    = 3'd4
   } cmd_code_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DONE  = 2'd0,
      KIND_MATCH = 2'd1,
      KIND_FULL  = 2'd2
   } kind_code_type;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [SYM_W-1:0] symbol;
      logic [ID_W-1:0]  pattern_id;
      logic [TAG_W-1:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [ID_W-1:0]  match_id;
      logic [TAG_W-1:0] match_tag;
      logic             last;
   } rsp_type;

   // One row of the goto table: the children of one node.
   typedef logic [ALPHABET-1:0][NODE_W-1:0] goto_row_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_INS_RD,
      OP_INS_STEP,
      OP_INS_NEW,
      OP_ERR_PUSH,
      OP_END,
      OP_RESTART,
      OP_B_INIT,
      OP_B_POP,
      OP_B_ROW,
      OP_B_LOAD,
      OP_B_NEXT,
      OP_B_START,
      OP_B_WALK,
      OP_B_WCHK,
      OP_B_WR,
      OP_DONE_PUSH,
      OP_S_INIT,
      OP_S_RD,
      OP_S_CHK,
      OP_M_RD,
      OP_M_CHK,
      OP_M_FIN
   } op_type;

   // Status flags returned by the datapath.
   typedef struct packed {
      logic       clr_last;
      logic [2:0] cmd;
      logic       sym_valid;
      logic       depth_full;
      logic       child_zero;
      logic       trie_full;
      logic       queue_empty;
      logic       hchild_zero;
      logic       h_root;
      logic       s_last;
      logic       walk_done;
      logic       scan_done;
      logic       node_zero;
      logic       pat_nz;
      logic       pend_valid;
      logic       can_push;
   } status_type;

endpackage

### rtl/mpsm_datapath.sv
// Datapath of the matcher: trie memories, cursors, work queue and result register.
// Depends on mpsm_pkg; driven one operation per cycle by mpsm_controller.
module mpsm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  mpsm_pkg::req_type   req_data,
   input  mpsm_pkg::op_type    op,
   output mpsm_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mpsm_pkg::rsp_type   rsp_data
);
   import mpsm_pkg::*;

   // Memories.
   goto_row_type      goto_mem  [NODES];
   logic [NODE_W-1:0] fail_mem  [NODES];
   logic [ID_W-1:0]   pat_mem   [NODES];
   logic [NODE_W-1:0] queue_mem [NODES];

   goto_row_type      goto_rd_ff;
   logic [NODE_W-1:0] fail_rd_ff;
   logic [ID_W-1:0]   pat_rd_ff;
   logic [NODE_W-1:0] queue_rd_ff;

   // Control and working registers.
   logic [NODE_W-1:0]  clr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [NODE_W-1:0]  ins_cur_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [NODE_W-1:0]  scan_cur_ff;
   logic [CNT_W-1:0]   head_ff;
   logic [CNT_W-1:0]   tail_ff;
   logic [SYM_W-1:0]   s_ff;
   logic [NODE_W-1:0]  h_ff;
   goto_row_type      hrow_ff;
   logic [NODE_W-1:0]  hfail_ff;
   logic [NODE_W-1:0]  f_ff;
   logic [NODE_W-1:0]  link_ff;
   logic [NODE_W-1:0]  node_ff;
   logic               pend_valid_ff;
   logic [ID_W-1:0]    pend_id_ff;
   req_type            item_ff;
   logic               out_valid_ff;
   rsp_type            out_ff;

   // Memory port controls.
   logic              goto_we, goto_re;
   logic [NODE_W-1:0] goto_wa, goto_ra;
   goto_row_type      goto_wd;
   logic              fail_we, fail_re;
   logic [NODE_W-1:0] fail_wa, fail_ra, fail_wd;
   logic              pat_we, pat_re;
   logic [NODE_W-1:0] pat_wa;
   logic [ID_W-1:0]   pat_wd;
   logic              queue_we, queue_re;
   logic [NODE_W-1:0] queue_wa, queue_wd;

   logic [NODE_W-1:0] child;
   logic [NODE_W-1:0] ins_edge;
   logic [NODE_W-1:0] walk_edge;
   logic [NODE_W-1:0] scan_edge;
   logic              can_push;
   logic              push;
   rsp_type           push_data;

   assign child     = hrow_ff[s_ff];
   assign ins_edge  = goto_rd_ff[item_ff.symbol];
   assign walk_edge = goto_rd_ff[s_ff];
   assign scan_edge = goto_rd_ff[item_ff.symbol];
   assign can_push  = !out_valid_ff || !rsp_stall;

   // Status back to the controller.
   always_comb begin
      status.clr_last    = (clr_ff == NODE_W'(NODES - 1));
      status.cmd         = item_ff.cmd;
      status.sym_valid   = (item_ff.symbol < SYM_W'(ALPHABET));
      status.depth_full  = (depth_ff >= DEPTH_W'(MAX_LEN));
      status.child_zero  = (ins_edge == '0);
      status.trie_full   = (count_ff == CNT_W'(NODES));
      status.queue_empty = (head_ff == tail_ff);
      status.hchild_zero = (child == '0);
      status.h_root      = (h_ff == '0);
      status.s_last      = (s_ff == SYM_W'(ALPHABET - 1));
      status.walk_done   = (walk_edge != '0) || (f_ff == '0);
      status.scan_done   = (scan_edge != '0) || (node_ff == '0);
      status.node_zero   = (node_ff == '0);
      status.pat_nz      = (pat_rd_ff != '0);
      status.pend_valid  = pend_valid_ff;
      status.can_push    = can_push;
   end

   // Memory port selection per operation.
   always_comb begin
      goto_we  = 1'b0;
      goto_re  = 1'b0;
      goto_wa  = clr_ff;
      goto_ra  = node_ff;
      goto_wd  = '0;
      fail_we  = 1'b0;
      fail_re  = 1'b0;
      fail_wa  = clr_ff;
      fail_ra  = node_ff;
      fail_wd  = '0;
      pat_we   = 1'b0;
      pat_re   = 1'b0;
      pat_wa   = clr_ff;
      pat_wd   = '0;
      queue_we = 1'b0;
      queue_re = 1'b0;
      queue_wa = tail_ff[NODE_W-1:0];
      queue_wd = child;
      case (op)
         OP_CLEAR: begin
            goto_we = 1'b1;
            fail_we = 1'b1;
            pat_we  = 1'b1;
         end
         OP_INS_RD: begin
            goto_re = 1'b1;
            goto_ra = ins_cur_ff;
         end
         OP_INS_NEW: begin
            goto_we = 1'b1;
            goto_wa = ins_cur_ff;
            goto_wd = goto_rd_ff;
            goto_wd[item_ff.symbol] = count_ff[NODE_W-1:0];
            fail_we = 1'b1;
            fail_wa = count_ff[NODE_W-1:0];
         end
         OP_END: begin
            pat_we = (ins_cur_ff != '0) && (item_ff.pattern_id <= ID_W'(MAX_PATTERNS));
            pat_wa = ins_cur_ff;
            pat_wd = item_ff.pattern_id;
         end
         OP_B_INIT: begin
            queue_we = 1'b1;
            queue_wa = '0;
            queue_wd = '0;
         end
         OP_B_POP: begin
            queue_re = 1'b1;
         end
         OP_B_ROW: begin
            goto_re = 1'b1;
            goto_ra = queue_rd_ff;
            fail_re = 1'b1;
            fail_ra = queue_rd_ff;
         end
         OP_B_WALK: begin
            goto_re = 1'b1;
            goto_ra = f_ff;
            fail_re = 1'b1;
            fail_ra = f_ff;
         end
         OP_B_WR: begin
            fail_we  = 1'b1;
            fail_wa  = child;
            fail_wd  = link_ff;
            queue_we = 1'b1;
         end
         OP_S_RD: begin
            goto_re = 1'b1;
            fail_re = 1'b1;
         end
         OP_M_RD: begin
            pat_re  = 1'b1;
            fail_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Goto table, one row per node.
   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem[goto_wa] <= goto_wd;
      end
      if (goto_re) begin
         goto_rd_ff <= goto_mem[goto_ra];
      end
   end

   // Failure links.
   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_wa] <= fail_wd;
      end
      if (fail_re) begin
         fail_rd_ff <= fail_mem[fail_ra];
      end
   end

   // Pattern tags.
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_wa] <= pat_wd;
      end
      if (pat_re) begin
         pat_rd_ff <= pat_mem[node_ff];
      end
   end

   // Breadth-first work queue.
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_wa] <= queue_wd;
      end
      if (queue_re) begin
         queue_rd_ff <= queue_mem[head_ff[NODE_W-1:0]];
      end
   end

   // Result to be pushed into the output register.
   always_comb begin
      push      = 1'b0;
      push_data = '0;
      case (op)
         OP_ERR_PUSH: begin
            push           = 1'b1;
            push_data.kind = KIND_FULL;
            push_data.last = 1'b1;
         end
         OP_DONE_PUSH: begin
            push           = 1'b1;
            push_data.kind = KIND_DONE;
            push_data.last = 1'b1;
         end
         OP_M_CHK: begin
            push                = status.pat_nz && pend_valid_ff;
            push_data.kind      = KIND_MATCH;
            push_data.match_id  = pend_id_ff;
            push_data.match_tag = item_ff.tag;
         end
         OP_M_FIN: begin
            push                = pend_valid_ff;
            push_data.kind      = KIND_MATCH;
            push_data.match_id  = pend_id_ff;
            push_data.match_tag = item_ff.tag;
            push_data.last      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (push) begin
         out_ff <= push_data;
      end
      case (op)
         OP_B_ROW: begin
            h_ff <= queue_rd_ff;
         end
         OP_B_LOAD: begin
            hrow_ff  <= goto_rd_ff;
            hfail_ff <= fail_rd_ff;
         end
         OP_B_START: begin
            f_ff    <= hfail_ff;
            link_ff <= '0;
         end
         OP_B_WCHK: begin
            if (status.walk_done) begin
               link_ff <= walk_edge;
            end else begin
               f_ff <= fail_rd_ff;
            end
         end
         OP_S_INIT: begin
            node_ff <= scan_cur_ff;
         end
         OP_S_CHK: begin
            node_ff <= status.scan_done ? scan_edge : fail_rd_ff;
         end
         OP_M_CHK: begin
            node_ff <= fail_rd_ff;
            if (status.pat_nz) begin
               pend_id_ff <= pat_rd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         count_ff      <= CNT_W'(1);
         ins_cur_ff    <= '0;
         depth_ff      <= '0;
         scan_cur_ff   <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         s_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (op)
            OP_CLEAR: begin
               clr_ff <= clr_ff + NODE_W'(1);
            end
            OP_INS_STEP: begin
               ins_cur_ff <= ins_edge;
               depth_ff   <= depth_ff + DEPTH_W'(1);
            end
            OP_INS_NEW: begin
               ins_cur_ff <= count_ff[NODE_W-1:0];
               count_ff   <= count_ff + CNT_W'(1);
               depth_ff   <= depth_ff + DEPTH_W'(1);
            end
            OP_END: begin
               ins_cur_ff <= '0;
               depth_ff   <= '0;
            end
            OP_RESTART: begin
               scan_cur_ff <= '0;
            end
            OP_B_INIT: begin
               head_ff <= '0;
               tail_ff <= CNT_W'(1);
            end
            OP_B_POP: begin
               head_ff <= head_ff + CNT_W'(1);
            end
            OP_B_LOAD: begin
               s_ff <= '0;
            end
            OP_B_NEXT: begin
               s_ff <= s_ff + SYM_W'(1);
            end
            OP_B_WR: begin
               tail_ff <= tail_ff + CNT_W'(1);
               s_ff    <= s_ff + SYM_W'(1);
            end
            OP_S_INIT: begin
               pend_valid_ff <= 1'b0;
            end
            OP_S_CHK: begin
               if (status.scan_done) begin
                  scan_cur_ff <= scan_edge;
               end
            end
            OP_M_CHK: begin
               if (status.pat_nz) begin
                  pend_valid_ff <= 1'b1;
               end
            end
            OP_M_FIN: begin
               pend_valid_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/mpsm_controller.sv
// Sequencer of the matcher: walks each command through its datapath operations.
// Depends on mpsm_pkg; drives mpsm_datapath through op and reads its status.
module mpsm_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  mpsm_pkg::status_type status,
   output mpsm_pkg::op_type     op,
   output logic                 req_stall
);
   import mpsm_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_CHK,
      ST_B_POP,
      ST_B_ROW,
      ST_B_LOAD,
      ST_B_SYM,
      ST_B_WALK,
      ST_B_WCHK,
      ST_B_WR,
      ST_S_RD,
      ST_S_CHK,
      ST_M_RD,
      ST_M_CHK
   } state_type;

   state_type state_ff, state_in;

   // Next state and the operation of this cycle.
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_CLEAR: begin
            op = OP_CLEAR;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            unique case (status.cmd)
               CMD_INSERT: begin
                  if (status.sym_valid && !status.depth_full) begin
                     op       = OP_INS_RD;
                     state_in = ST_INS_CHK;
                  end
               end
               CMD_END: begin
                  op = OP_END;
               end
               CMD_BUILD: begin
                  op       = OP_B_INIT;
                  state_in = ST_B_POP;
               end
               CMD_RESTART: begin
                  op = OP_RESTART;
               end
               CMD_SCAN: begin
                  if (status.sym_valid) begin
                     op       = OP_S_INIT;
                     state_in = ST_S_RD;
                  end else begin
                     op = OP_RESTART;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_CHK: begin
            if (!status.child_zero) begin
               op       = OP_INS_STEP;
               state_in = ST_IDLE;
            end else if (!status.trie_full) begin
               op       = OP_INS_NEW;
               state_in = ST_IDLE;
            end else if (status.can_push) begin
               op       = OP_ERR_PUSH;
               state_in = ST_IDLE;
            end
         end
         ST_B_POP: begin
            if (!status.queue_empty) begin
               op       = OP_B_POP;
               state_in = ST_B_ROW;
            end else if (status.can_push) begin
               op       = OP_DONE_PUSH;
               state_in = ST_IDLE;
            end
         end
         ST_B_ROW: begin
            op       = OP_B_ROW;
            state_in = ST_B_LOAD;
         end
         ST_B_LOAD: begin
            op       = OP_B_LOAD;
            state_in = ST_B_SYM;
         end
         ST_B_SYM: begin
            if (status.hchild_zero) begin
               op       = OP_B_NEXT;
               state_in = status.s_last ? ST_B_POP : ST_B_SYM;
            end else begin
               op       = OP_B_START;
               state_in = status.h_root ? ST_B_WR : ST_B_WALK;
            end
         end
         ST_B_WALK: begin
            op       = OP_B_WALK;
            state_in = ST_B_WCHK;
         end
         ST_B_WCHK: begin
            op       = OP_B_WCHK;
            state_in = status.walk_done ? ST_B_WR : ST_B_WALK;
         end
         ST_B_WR: begin
            op       = OP_B_WR;
            state_in = status.s_last ? ST_B_POP : ST_B_SYM;
         end
         ST_S_RD: begin
            op       = OP_S_RD;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            op       = OP_S_CHK;
            state_in = status.scan_done ? ST_M_RD : ST_S_RD;
         end
         ST_M_RD: begin
            if (!status.node_zero) begin
               op       = OP_M_RD;
               state_in = ST_M_CHK;
            end else if (!status.pend_valid || status.can_push) begin
               op       = OP_M_FIN;
               state_in = ST_IDLE;
            end
         end
         ST_M_CHK: begin
            if (!(status.pat_nz && status.pend_valid && !status.can_push)) begin
               op       = OP_M_CHK;
               state_in = ST_M_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### rtl/multi_pattern_string_matcher_core.sv
// Top level of the Aho-Corasick multi-pattern matcher over 26 letters.
// Depends on mpsm_pkg, mpsm_controller and mpsm_datapath.
//
// After reset the block sweeps its trie memories, one node per cycle, and stalls
// the input until that is done. Then one beat is worked at a time. A scanned
// letter is dispatched, then visits each node while searching for an edge (the
// current state and every failure-link hop), each step one registered read of
// the goto and failure memories, then each node on the output chain, each step
// one registered read of the pattern and failure memories, and then closes. A
// build is dispatched, fetches the row of each trie node in turn, steps through
// every letter of each node, writes each child's link after walking the failure
// chain for a child of a non-root node, and closes. A result waits in an output
// register, so the datapath runs on until it must hand over another.
module multi_pattern_string_matcher_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mpsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mpsm_pkg::rsp_type rsp_data
);
   import mpsm_pkg::*;

   op_type     op;
   status_type status;
   logic       req_accept;

   assign req_accept = req_valid && !req_stall;

   mpsm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .status     (status),
      .op         (op),
      .req_stall  (req_stall)
   );

   mpsm_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .op         (op),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
